FILE: rtl/mbrtu_pkg.sv
// types, constants and the crc step shared by the modbus rtu master engine
`timescale 1ns / 1ps
`default_nettype none
package mbrtu_pkg;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_PAYLOAD = 2'd1;
    localparam logic [1:0] ACT_RX      = 2'd2;
    localparam logic [1:0] ACT_END     = 2'd3;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_RESP   = 3'd1;
    localparam logic [2:0] ST_ECHO      = 3'd2;
    localparam logic [2:0] ST_BAD_RESP  = 3'd3;
    localparam logic [2:0] ST_CRC       = 3'd4;
    localparam logic [2:0] ST_ILL_FUNC  = 3'd5;
    localparam logic [2:0] ST_ILL_ADDR  = 3'd6;
    localparam logic [2:0] ST_ILL_VALUE = 3'd7;

    localparam logic [7:0] FC_WR_COIL  = 8'h05;
    localparam logic [7:0] FC_WR_REG   = 8'h06;
    localparam logic [7:0] FC_WR_COILS = 8'h0F;
    localparam logic [7:0] FC_WR_REGS  = 8'h10;
    localparam logic [7:0] FC_EXC_BIT  = 8'h80;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int QDEPTH = 4;

    typedef enum logic [2:0] {
        OP_FRAME,
        OP_PAY_COIL,
        OP_PAY_REG,
        OP_RD_COILS,
        OP_RD_REG,
        OP_STATUS
    } cmd_op_t;

    // fc carries the crc flag or element count, val the data, q the index
    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  sid;
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [15:0] val;
        logic [10:0] q;
    } cmd_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mbrtu_front.sv
// front end: takes beats, keeps request and response parser state, issues commands
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_front #(
    parameter int FRAME_BYTES  = 256,
    parameter int MAX_QUANTITY = 2000
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_wr_en,
    input  wire  [7:0]        cfg_wr_data,
    input  wire               in_valid,
    input  wire  [1:0]        in_action,
    input  wire  [7:0]        in_fc,
    input  wire  [15:0]       in_addr,
    input  wire  [15:0]       in_value,
    input  wire  [10:0]       in_qty,
    input  wire  [15:0]       in_word,
    input  wire  [7:0]        in_rx,
    output logic              push,
    output mbrtu_pkg::cmd_t   push_cmd
);
    import mbrtu_pkg::*;

    logic [7:0]  sid_reg;
    logic [7:0]  req_code_reg, req_code_next;
    logic [15:0] req_address_reg, req_address_next;
    logic [10:0] req_quantity_reg, req_quantity_next;
    logic [10:0] element_count_reg, element_count_next;
    logic [7:0]  pack_byte_reg, pack_byte_next;
    logic [8:0]  rx_position_reg, rx_position_next;
    logic [7:0]  rx_code_reg, rx_code_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic [15:0] echo_word_reg, echo_word_next;
    logic [7:0]  exception_code_reg, exception_code_next;
    logic [2:0]  first_error_reg, first_error_next;
    logic        error_seen_reg, error_seen_next;
    logic [10:0] data_index_reg, data_index_next;

    logic [11:0] exp_count;
    logic [12:0] rx_total;
    logic        rx_done;
    logic        is_read;
    logic        known_new;
    logic [8:0]  p;
    logic [12:0] p2;
    logic [15:0] word;
    logic [10:0] remain;
    logic [3:0]  ncoil;
    logic [7:0]  pack_new;
    logic [10:0] ec_inc;
    logic [12:0] q13;

    always_comb begin
        is_read   = (req_code_reg >= 8'd1) && (req_code_reg <= 8'd4);
        exp_count = (req_code_reg <= 8'd2) ? {4'd0, 5'd0, 3'd0} |
                    12'((13'({2'd0, req_quantity_reg}) + 13'd7) >> 3) :
                    {req_quantity_reg, 1'b0};
        if (rx_code_reg != req_code_reg)   rx_total = 13'd5;
        else if (is_read)                  rx_total = 13'd5 + {1'b0, exp_count};
        else                               rx_total = 13'd8;
        rx_done = (rx_position_reg >= 9'd2) && ({4'd0, rx_position_reg} >= rx_total);
    end

    always_comb begin
        req_code_next       = req_code_reg;
        req_address_next    = req_address_reg;
        req_quantity_next   = req_quantity_reg;
        element_count_next  = element_count_reg;
        pack_byte_next      = pack_byte_reg;
        rx_position_next    = rx_position_reg;
        rx_code_next        = rx_code_reg;
        rx_crc_next         = rx_crc_reg;
        hold_byte_next      = hold_byte_reg;
        echo_word_next      = echo_word_reg;
        exception_code_next = exception_code_reg;
        first_error_next    = first_error_reg;
        error_seen_next     = error_seen_reg;
        data_index_next     = data_index_reg;
        push       = 1'b0;
        push_cmd   = '0;
        push_cmd.sid = sid_reg;
        p      = rx_position_reg;
        p2     = {4'd0, rx_position_reg} + 13'd2;
        word   = {hold_byte_reg, in_rx};
        remain = req_quantity_reg - data_index_reg;
        ncoil  = (remain >= 11'd8) ? 4'd8 : remain[3:0];
        pack_new = pack_byte_reg | (8'(in_word[0]) << element_count_reg[2:0]);
        ec_inc = element_count_reg + 11'd1;
        q13    = {2'd0, in_qty};
        known_new = ((in_fc >= 8'd1) && (in_fc <= 8'd6)) || in_fc == FC_WR_COILS ||
                    in_fc == FC_WR_REGS;

        if (in_valid) begin
            case (in_action)
                ACT_START: begin
                    rx_position_next = '0; rx_code_next = '0; rx_crc_next = CRC_INIT;
                    hold_byte_next = '0; exception_code_next = '0;
                    data_index_next = '0;
                    req_code_next = in_fc;
                    req_address_next = in_addr;
                    req_quantity_next = in_qty;
                    element_count_next = '0;
                    pack_byte_next = '0;
                    if (in_fc == FC_WR_COIL)     echo_word_next = (in_value != 16'd0) ? 16'hFF00 : 16'd0;
                    else if (in_fc == FC_WR_REG) echo_word_next = in_value;
                    else                         echo_word_next = {5'd0, in_qty};
                    push = 1'b1;
                    push_cmd.op = OP_FRAME;
                    push_cmd.fc = in_fc;
                    push_cmd.addr = in_addr;
                    push_cmd.val = in_value;
                    push_cmd.q = in_qty;
                    error_seen_next = 1'b0;
                    first_error_next = ST_OK;
                    if (!known_new) begin
                        push_cmd.op = OP_STATUS; push_cmd.fc = {5'd0, ST_ILL_FUNC};
                    end else if ((in_fc <= 8'd4 && q13 > 13'(MAX_QUANTITY)) ||
                                 (in_fc == FC_WR_COILS && (in_qty == 11'd0 ||
                                  q13 > 13'(MAX_QUANTITY) ||
                                  13'd9 + ((q13 + 13'd7) >> 3) > 13'(FRAME_BYTES))) ||
                                 (in_fc == FC_WR_REGS && (in_qty == 11'd0 ||
                                  q13 > 13'(MAX_QUANTITY) ||
                                  13'd9 + {q13[11:0], 1'b0} > 13'(FRAME_BYTES)))) begin
                        push_cmd.op = OP_STATUS; push_cmd.fc = {5'd0, ST_ILL_VALUE};
                    end
                    if (push_cmd.op == OP_STATUS) begin
                        req_code_next = '0;
                        req_quantity_next = '0;
                        error_seen_next = 1'b1;
                        first_error_next = push_cmd.fc[2:0];
                    end
                end
                ACT_PAYLOAD: begin
                    if ((req_code_reg == FC_WR_COILS || req_code_reg == FC_WR_REGS) &&
                        element_count_reg < req_quantity_reg) begin
                        element_count_next = ec_inc;
                        push_cmd.fc = {7'd0, ec_inc == req_quantity_reg};
                        if (req_code_reg == FC_WR_COILS) begin
                            if (ec_inc[2:0] == 3'd0 || ec_inc == req_quantity_reg) begin
                                push = 1'b1;
                                push_cmd.op = OP_PAY_COIL;
                                push_cmd.val = {8'd0, pack_new};
                                pack_byte_next = '0;
                            end else begin
                                pack_byte_next = pack_new;
                            end
                        end else begin
                            push = 1'b1;
                            push_cmd.op = OP_PAY_REG;
                            push_cmd.val = in_word;
                        end
                    end
                end
                ACT_RX: begin
                    if (!(error_seen_reg || rx_done)) begin
                        if ({4'd0, rx_position_reg} >= 13'(FRAME_BYTES)) begin
                            error_seen_next = 1'b1; first_error_next = ST_BAD_RESP;
                        end else begin
                            rx_position_next = rx_position_reg + 9'd1;
                            if (p == 9'd0) begin
                                rx_crc_next = crc_step(rx_crc_reg, in_rx);
                                if (in_rx != sid_reg) begin
                                    error_seen_next = 1'b1; first_error_next = ST_ECHO;
                                end
                            end else if (p == 9'd1) begin
                                rx_crc_next = crc_step(rx_crc_reg, in_rx);
                                rx_code_next = in_rx;
                                if (!(((req_code_reg >= 8'd1) && (req_code_reg <= 8'd6)) ||
                                      req_code_reg == FC_WR_COILS ||
                                      req_code_reg == FC_WR_REGS) ||
                                    (in_rx != req_code_reg &&
                                     in_rx != (req_code_reg | FC_EXC_BIT))) begin
                                    error_seen_next = 1'b1; first_error_next = ST_ECHO;
                                end
                            end else if (p2 < rx_total) begin
                                rx_crc_next = crc_step(rx_crc_reg, in_rx);
                                if (rx_code_reg != req_code_reg) begin
                                    exception_code_next = in_rx;
                                end else if (!is_read) begin
                                    if (!p[0]) begin
                                        hold_byte_next = in_rx;
                                    end else if (word != ((p == 9'd3) ? req_address_reg
                                                                     : echo_word_reg)) begin
                                        error_seen_next = 1'b1; first_error_next = ST_ECHO;
                                    end
                                end else if (p == 9'd2) begin
                                    if ({4'd0, in_rx} != exp_count) begin
                                        error_seen_next = 1'b1;
                                        first_error_next = ST_BAD_RESP;
                                    end
                                end else if (req_code_reg <= 8'd2) begin
                                    if (ncoil != 4'd0) begin
                                        push = 1'b1;
                                        push_cmd.op = OP_RD_COILS;
                                        push_cmd.fc = {4'd0, ncoil};
                                        push_cmd.val = {8'd0, in_rx};
                                        push_cmd.q = data_index_reg;
                                        data_index_next = data_index_reg + {7'd0, ncoil};
                                    end
                                end else if (p[0]) begin
                                    hold_byte_next = in_rx;
                                end else begin
                                    push = 1'b1;
                                    push_cmd.op = OP_RD_REG;
                                    push_cmd.val = word;
                                    push_cmd.q = data_index_reg;
                                    data_index_next = data_index_reg + 11'd1;
                                end
                            end else if (p2 == rx_total) begin
                                hold_byte_next = in_rx;
                            end else if ({in_rx, hold_byte_reg} != rx_crc_reg) begin
                                error_seen_next = 1'b1; first_error_next = ST_CRC;
                            end else if (rx_code_reg != req_code_reg) begin
                                error_seen_next = 1'b1;
                                case (exception_code_reg)
                                    8'd1:    first_error_next = ST_ILL_FUNC;
                                    8'd2:    first_error_next = ST_ILL_ADDR;
                                    8'd3:    first_error_next = ST_ILL_VALUE;
                                    default: first_error_next = ST_BAD_RESP;
                                endcase
                            end
                        end
                    end
                end
                default: begin
                    push = 1'b1;
                    push_cmd.op = OP_STATUS;
                    if (error_seen_reg)              push_cmd.fc = {5'd0, first_error_reg};
                    else if (rx_position_reg == 9'd0) push_cmd.fc = {5'd0, ST_NO_RESP};
                    else if (rx_done)                push_cmd.fc = {5'd0, ST_OK};
                    else                             push_cmd.fc = {5'd0, ST_BAD_RESP};
                    rx_position_next = '0; rx_code_next = '0; rx_crc_next = CRC_INIT;
                    hold_byte_next = '0; exception_code_next = '0;
                    first_error_next = ST_OK; error_seen_next = 1'b0;
                    data_index_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sid_reg            <= 8'd1;
            req_code_reg       <= '0;
            req_address_reg    <= '0;
            req_quantity_reg   <= '0;
            element_count_reg  <= '0;
            pack_byte_reg      <= '0;
            rx_position_reg    <= '0;
            rx_code_reg        <= '0;
            rx_crc_reg         <= CRC_INIT;
            hold_byte_reg      <= '0;
            echo_word_reg      <= '0;
            exception_code_reg <= '0;
            first_error_reg    <= ST_OK;
            error_seen_reg     <= 1'b0;
            data_index_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                sid_reg <= cfg_wr_data;
            end
            req_code_reg       <= req_code_next;
            req_address_reg    <= req_address_next;
            req_quantity_reg   <= req_quantity_next;
            element_count_reg  <= element_count_next;
            pack_byte_reg      <= pack_byte_next;
            rx_position_reg    <= rx_position_next;
            rx_code_reg        <= rx_code_next;
            rx_crc_reg         <= rx_crc_next;
            hold_byte_reg      <= hold_byte_next;
            echo_word_reg      <= echo_word_next;
            exception_code_reg <= exception_code_next;
            first_error_reg    <= first_error_next;
            error_seen_reg     <= error_seen_next;
            data_index_reg     <= data_index_next;
        end
    end

    a_err_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !error_seen_reg |-> first_error_reg == ST_OK) else $error("stale first error");
    a_data_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        data_index_reg <= req_quantity_reg) else $error("read index past quantity");
    a_elem_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        element_count_reg <= req_quantity_reg) else $error("payload count past quantity");

endmodule
`default_nettype wire

FILE: rtl/mbrtu_queue.sv
// short command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_queue (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  mbrtu_pkg::cmd_t   push_cmd,
    input  wire               pop,
    output logic              full,
    output logic              not_empty,
    output mbrtu_pkg::cmd_t   head
);
    import mbrtu_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    cmd_t            slot_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full      = count_reg == (PW+1)'(QDEPTH);
    assign not_empty = count_reg != '0;
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !not_empty |-> !pop) else $error("queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(QDEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: rtl/mbrtu_back.sv
// back end: expands commands into output beats, keeps the transmit crc
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_back (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cmd_valid,
    input  mbrtu_pkg::cmd_t   cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [39:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import mbrtu_pkg::*;

    logic [2:0]  step_reg;
    logic [15:0] crc_reg;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  tx_reg;
    logic        last_reg;
    logic [10:0] idx_reg;
    logic [15:0] val_reg;
    logic [2:0]  st_reg;

    logic        adv, end_cmd, is_byte, is_crc;
    logic [1:0]  kind_b;
    logic [7:0]  tx_b;
    logic        last_b;
    logic [10:0] idx_b;
    logic [15:0] val_b;
    logic [2:0]  st_b;
    logic [15:0] crc_in;
    logic [3:0]  crc_at;

    always_comb begin
        adv     = cmd_valid && (!valid_reg || m_tready);
        crc_in  = (cmd.op == OP_FRAME && step_reg == 3'd0) ? CRC_INIT : crc_reg;
        kind_b  = KIND_TX;
        tx_b    = '0;
        last_b  = 1'b0;
        idx_b   = '0;
        val_b   = '0;
        st_b    = ST_OK;
        is_byte = 1'b0;
        is_crc  = 1'b0;
        end_cmd = 1'b0;
        crc_at  = 4'd8;
        case (cmd.op)
            OP_FRAME: begin
                is_byte = 1'b1;
                crc_at  = (cmd.fc == FC_WR_COILS || cmd.fc == FC_WR_REGS) ? 4'd8 : 4'd6;
                case (step_reg)
                    3'd0: tx_b = cmd.sid;
                    3'd1: tx_b = cmd.fc;
                    3'd2: tx_b = cmd.addr[15:8];
                    3'd3: tx_b = cmd.addr[7:0];
                    3'd4: begin
                        if (cmd.fc == FC_WR_COIL)     tx_b = (cmd.val != 16'd0) ? 8'hFF : 8'h00;
                        else if (cmd.fc == FC_WR_REG) tx_b = cmd.val[15:8];
                        else                          tx_b = {5'd0, cmd.q[10:8]};
                    end
                    3'd5: begin
                        if (cmd.fc == FC_WR_COIL)     tx_b = 8'h00;
                        else if (cmd.fc == FC_WR_REG) tx_b = cmd.val[7:0];
                        else                          tx_b = cmd.q[7:0];
                    end
                    default: begin
                        if (cmd.fc == FC_WR_COILS) begin
                            tx_b = 8'((12'({1'b0, cmd.q}) + 12'd7) >> 3);
                            end_cmd = 1'b1;
                        end else if (cmd.fc == FC_WR_REGS) begin
                            tx_b = {cmd.q[6:0], 1'b0};
                            end_cmd = 1'b1;
                        end
                    end
                endcase
            end
            OP_PAY_COIL: begin
                is_byte = 1'b1;
                crc_at  = 4'd1;
                tx_b    = cmd.val[7:0];
                end_cmd = (step_reg == 3'd0) && !cmd.fc[0];
            end
            OP_PAY_REG: begin
                is_byte = 1'b1;
                crc_at  = 4'd2;
                tx_b    = (step_reg == 3'd0) ? cmd.val[15:8] : cmd.val[7:0];
                end_cmd = (step_reg == 3'd1) && !cmd.fc[0];
            end
            OP_RD_COILS: begin
                kind_b  = KIND_READ;
                idx_b   = cmd.q + {8'd0, step_reg};
                val_b   = {15'd0, cmd.val[step_reg]};
                end_cmd = ({1'b0, step_reg} + 4'd1) == cmd.fc[3:0];
            end
            OP_RD_REG: begin
                kind_b  = KIND_READ;
                idx_b   = cmd.q;
                val_b   = cmd.val;
                end_cmd = 1'b1;
            end
            default: begin
                kind_b  = KIND_STATUS;
                last_b  = 1'b1;
                st_b    = cmd.fc[2:0];
                end_cmd = 1'b1;
            end
        endcase
        if (is_byte && {1'b0, step_reg} >= crc_at) begin
            is_crc = 1'b1;
            if ({1'b0, step_reg} == crc_at) begin
                tx_b = crc_in[7:0];
            end else begin
                tx_b = crc_in[15:8];
                last_b = 1'b1;
                end_cmd = 1'b1;
            end
        end
        pop = adv && end_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                valid_reg <= 1'b1;
                step_reg  <= end_cmd ? 3'd0 : step_reg + 3'd1;
                if (is_byte && !is_crc) begin
                    crc_reg <= crc_step(crc_in, tx_b);
                end else begin
                    crc_reg <= crc_in;
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg <= kind_b;
            tx_reg   <= tx_b;
            last_reg <= last_b;
            idx_reg  <= idx_b;
            val_reg  <= val_b;
            st_reg   <= st_b;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, st_reg, val_reg, idx_reg, tx_reg};

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && cmd.op == OP_STATUS |-> pop) else $error("status beat not closing command");
    a_step_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && !adv |=> $stable(step_reg)) else $error("step moved while stalled");
    a_read_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && kind_reg == KIND_READ |-> !last_reg) else $error("read beat marked last");

endmodule
`default_nettype wire

FILE: rtl/modbus_rtu_master_frame_engine_core.sv
// top level of the modbus rtu master frame engine
`timescale 1ns / 1ps
`default_nettype none
// Modbus RTU master frame engine.
// s_ channel: one beat per item; s_tuser is the action (start, payload
// element, response byte, end of response), s_tdata the request fields.
// m_ channel: result beats; m_tuser is the kind (transmit byte, read element,
// status), m_tlast marks the last frame byte and every status beat. The user
// writes the unit address (cfg_wr_en / cfg_wr_data) only while idle; unchecked.
// The front end handles one input beat per cycle while the queue has room and
// places at most one command into a four-entry queue; the back end expands
// each command into output beats (a start up to 8, a read coil byte up to 8).
// A command is registered in the queue, then in the back end's output stage.
// The back end sets the rate: one output beat per cycle while m_tready is high.
// Reset (aresetn low, synchronous) clears the parser, the queue and the
// output stage and sets the unit address to 1.
// When the receiver stalls, the output beat holds, the queue fills, and
// s_tready drops once the queue is full.
module modbus_rtu_master_frame_engine_core #(
    parameter int FRAME_BYTES  = 256,
    parameter int MAX_QUANTITY = 2000
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [7:0]  cfg_wr_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    // func_code[7:0], start_address[23:8], single_value[39:24], quantity[50:40],
    // payload_word[66:51], rx_byte[74:67]
    input  wire  [79:0] s_tdata,
    // action[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tx_byte[7:0], read_index[18:8], read_value[34:19], status[37:35]
    output logic [39:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import mbrtu_pkg::*;

    logic  push, pop, full, not_empty;
    cmd_t  push_cmd, head;

    assign s_tready = !full;

    mbrtu_front #(
        .FRAME_BYTES  (FRAME_BYTES),
        .MAX_QUANTITY (MAX_QUANTITY)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid && !full),
        .in_action   (s_tuser),
        .in_fc       (s_tdata[7:0]),
        .in_addr     (s_tdata[23:8]),
        .in_value    (s_tdata[39:24]),
        .in_qty      (s_tdata[50:40]),
        .in_word     (s_tdata[66:51]),
        .in_rx       (s_tdata[74:67]),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    mbrtu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    mbrtu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (not_empty),
        .cmd       (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the modbus rtu master frame engine
`timescale 1ns / 1ps
module tb;
    import mbrtu_pkg::*;

    localparam logic [7:0] FC_RD_COILS = 8'h01;
    localparam logic [7:0] FC_RD_DISC  = 8'h02;
    localparam logic [7:0] FC_RD_HOLD  = 8'h03;
    localparam logic [7:0] FC_RD_INPUT = 8'h04;
    localparam int FRAME_MAX = 256;
    localparam int QTY_MAX   = 2000;
    localparam int RSP_NORMAL = 0;
    localparam int RSP_EXCEPT = 1;
    localparam int RSP_BROKEN = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic        last;
        logic [10:0] idx;
        logic [15:0] val;
        logic [2:0]  st;
    } beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = 80'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    modbus_rtu_master_frame_engine_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // engine shadow state
    logic [7:0]  unit_id;
    logic [7:0]  req_fc, pack, rx_fc, hold, exc;
    logic [15:0] req_addr, req_val, tx_crc, rx_crc, echo_w;
    logic [10:0] req_qty, elem_cnt, data_idx;
    int          rx_pos;
    logic [2:0]  first_err;
    logic        err_seen;

    beat_t exp_q[$];
    int errors = 0, n_items = 0, n_frames = 0, n_reads = 0, n_status = 0;
    int burst_left = 0;

    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic void emit(logic [1:0] k, logic [7:0] tx, logic l, logic [10:0] ix,
                                 logic [15:0] v, logic [2:0] s);
        exp_q.push_back('{k, tx, l, ix, v, s});
    endfunction

    function automatic void tx_out(logic [7:0] b);
        tx_crc = crc16_byte(tx_crc, b);
        emit(KIND_TX, b, 1'b0, 11'd0, 16'd0, ST_OK);
    endfunction

    function automatic void tx_crc_out();
        emit(KIND_TX, tx_crc[7:0], 1'b0, 11'd0, 16'd0, ST_OK);
        emit(KIND_TX, tx_crc[15:8], 1'b1, 11'd0, 16'd0, ST_OK);
    endfunction

    function automatic bit fc_known(logic [7:0] c);
        return (c >= FC_RD_COILS && c <= FC_WR_REG) || c == FC_WR_COILS || c == FC_WR_REGS;
    endfunction

    function automatic bit fc_read(logic [7:0] c);
        return c >= FC_RD_COILS && c <= FC_RD_INPUT;
    endfunction

    function automatic int data_count();
        return (req_fc <= FC_RD_DISC) ? (int'(req_qty) + 7) >> 3 : int'(req_qty) * 2;
    endfunction

    function automatic int frame_len();
        if (rx_fc != req_fc) return 5;
        if (fc_read(req_fc)) return 5 + data_count();
        return 8;
    endfunction

    function automatic bit frame_done();
        return rx_pos >= 2 && rx_pos >= frame_len();
    endfunction

    function automatic void flag_err(logic [2:0] s);
        if (!err_seen) begin
            err_seen = 1'b1;
            first_err = s;
        end
    endfunction

    function automatic void parser_clear();
        rx_pos = 0; rx_fc = 0; rx_crc = 16'hFFFF; hold = 0;
        exc = 0; first_err = 0; err_seen = 0; data_idx = 0;
    endfunction

    function automatic void engine_reset();
        unit_id = 8'd1;
        req_fc = 0; req_addr = 0; req_val = 0; req_qty = 0;
        tx_crc = 16'hFFFF; elem_cnt = 0; pack = 0; echo_w = 0;
        parser_clear();
    endfunction

    function automatic void refuse(logic [2:0] s);
        req_fc = 0;
        req_qty = 0;
        flag_err(s);
        emit(KIND_STATUS, 8'd0, 1'b1, 11'd0, 16'd0, s);
    endfunction

    function automatic void predict_start(logic [7:0] fc, logic [15:0] addr,
                                          logic [15:0] val, logic [10:0] q);
        int n;
        parser_clear();
        req_fc = fc; req_addr = addr; req_val = val; req_qty = q;
        tx_crc = 16'hFFFF; elem_cnt = 0; pack = 0;
        n = q;
        if (fc == FC_WR_COIL) echo_w = (val != 0) ? 16'hFF00 : 16'h0000;
        else if (fc == FC_WR_REG) echo_w = val;
        else echo_w = {5'd0, q};
        if (!fc_known(fc)) begin
            refuse(ST_ILL_FUNC);
            return;
        end
        if ((fc_read(fc) && n > QTY_MAX)
            || (fc == FC_WR_COILS && (n == 0 || n > QTY_MAX || 9 + ((n + 7) >> 3) > FRAME_MAX))
            || (fc == FC_WR_REGS && (n == 0 || n > QTY_MAX || 9 + 2 * n > FRAME_MAX))) begin
            refuse(ST_ILL_VALUE);
            return;
        end
        tx_out(unit_id);
        tx_out(fc);
        tx_out(addr[15:8]);
        tx_out(addr[7:0]);
        if (fc == FC_WR_COIL) begin
            tx_out((val != 0) ? 8'hFF : 8'h00);
            tx_out(8'h00);
            tx_crc_out();
        end else if (fc == FC_WR_REG) begin
            tx_out(val[15:8]);
            tx_out(val[7:0]);
            tx_crc_out();
        end else begin
            tx_out({5'd0, q[10:8]});
            tx_out(q[7:0]);
            if (fc == FC_WR_COILS) tx_out(8'((n + 7) >> 3));
            else if (fc == FC_WR_REGS) tx_out(8'(n * 2));
            else tx_crc_out();
        end
    endfunction

    function automatic void predict_payload(logic [15:0] w);
        if ((req_fc != FC_WR_COILS && req_fc != FC_WR_REGS) || elem_cnt >= req_qty) return;
        if (req_fc == FC_WR_COILS) begin
            pack[elem_cnt[2:0]] = w[0];
            elem_cnt++;
            if (elem_cnt[2:0] == 0 || elem_cnt == req_qty) begin
                tx_out(pack);
                pack = 0;
            end
        end else begin
            tx_out(w[15:8]);
            tx_out(w[7:0]);
            elem_cnt++;
        end
        if (elem_cnt == req_qty) tx_crc_out();
    endfunction

    function automatic void predict_data(int p, logic [7:0] b);
        logic [15:0] word;
        if (rx_fc != req_fc) begin
            exc = b;
        end else if (!fc_read(req_fc)) begin
            if (p % 2 == 0) begin
                hold = b;
            end else begin
                word = {hold, b};
                if (word != ((p == 3) ? req_addr : echo_w)) flag_err(ST_ECHO);
            end
        end else if (p == 2) begin
            if (int'(b) != data_count()) flag_err(ST_BAD_RESP);
        end else if (req_fc <= FC_RD_DISC) begin
            for (int k = 0; k < 8; k++) begin
                if (data_idx < req_qty) begin
                    emit(KIND_READ, 8'd0, 1'b0, data_idx, {15'd0, b[k]}, ST_OK);
                    data_idx++;
                end
            end
        end else if ((p - 3) % 2 == 0) begin
            hold = b;
        end else begin
            emit(KIND_READ, 8'd0, 1'b0, data_idx, {hold, b}, ST_OK);
            data_idx++;
        end
    endfunction

    function automatic void predict_rx(logic [7:0] b);
        int p, total;
        if (err_seen || frame_done()) return;
        if (rx_pos >= FRAME_MAX) begin
            flag_err(ST_BAD_RESP);
            return;
        end
        p = rx_pos;
        rx_pos++;
        if (p == 0) begin
            rx_crc = crc16_byte(rx_crc, b);
            if (b != unit_id) flag_err(ST_ECHO);
            return;
        end
        if (p == 1) begin
            rx_crc = crc16_byte(rx_crc, b);
            rx_fc = b;
            if (!fc_known(req_fc) || (b != req_fc && b != (req_fc | FC_EXC_BIT)))
                flag_err(ST_ECHO);
            return;
        end
        total = frame_len();
        if (p + 2 < total) begin
            rx_crc = crc16_byte(rx_crc, b);
            predict_data(p, b);
        end else if (p + 2 == total) begin
            hold = b;
        end else if ({b, hold} != rx_crc) begin
            flag_err(ST_CRC);
        end else if (rx_fc != req_fc) begin
            if (exc == 8'd1) flag_err(ST_ILL_FUNC);
            else if (exc == 8'd2) flag_err(ST_ILL_ADDR);
            else if (exc == 8'd3) flag_err(ST_ILL_VALUE);
            else flag_err(ST_BAD_RESP);
        end
    endfunction

    function automatic void predict_end();
        logic [2:0] s;
        if (err_seen) s = first_err;
        else if (rx_pos == 0) s = ST_NO_RESP;
        else if (frame_done()) s = ST_OK;
        else s = ST_BAD_RESP;
        emit(KIND_STATUS, 8'd0, 1'b1, 11'd0, 16'd0, s);
        parser_clear();
    endfunction

    task automatic push_beat(input logic [1:0] act, input logic [7:0] fc,
                             input logic [15:0] addr, input logic [15:0] val,
                             input logic [10:0] q, input logic [15:0] pw, input logic [7:0] rb);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
            burst_left = ($urandom % 4 == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, rb, pw, q, val, addr, fc};
        forever begin
            @(negedge aclk);
            if (s_tready) begin
                @(posedge aclk);
                break;
            end
        end
        n_items++;
        case (act)
            ACT_START:   predict_start(fc, addr, val, q);
            ACT_PAYLOAD: predict_payload(pw);
            ACT_RX:      predict_rx(rb);
            default:     predict_end();
        endcase
    endtask

    task automatic push_simple(input logic [1:0] act, input logic [15:0] pw, input logic [7:0] rb);
        push_beat(act, 8'($urandom), 16'($urandom), 16'($urandom), 11'($urandom), pw, rb);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (exp_q.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic set_unit(input logic [7:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        unit_id = v;
    endtask

    task automatic run_request(input logic [7:0] fc, input logic [10:0] q, input int mode);
        logic [7:0]  rsp[$];
        logic [15:0] addr, val, c, ew;
        int cnt, k, n;
        addr = 16'($urandom);
        val  = ($urandom % 4 == 0) ? 16'd0 : 16'($urandom);
        push_beat(ACT_START, fc, addr, val, q, 16'($urandom), 8'($urandom));
        if (fc == FC_WR_COILS || fc == FC_WR_REGS) begin
            n = int'(q) + (($urandom % 6 == 0) ? 1 : 0);
            for (int i = 0; i < n; i++) push_simple(ACT_PAYLOAD, 16'($urandom), 8'($urandom));
        end
        rsp.push_back(unit_id);
        if (mode == RSP_EXCEPT) begin
            rsp.push_back(fc | FC_EXC_BIT);
            k = $urandom % 5;
            rsp.push_back(k == 4 ? 8'($urandom) : 8'(k));
        end else begin
            rsp.push_back(fc);
            if (fc_read(fc)) begin
                cnt = (fc <= FC_RD_DISC) ? (int'(q) + 7) >> 3 : int'(q) * 2;
                rsp.push_back(8'(cnt));
                for (int i = 0; i < cnt; i++) rsp.push_back(8'($urandom));
            end else begin
                rsp.push_back(addr[15:8]);
                rsp.push_back(addr[7:0]);
                if (fc == FC_WR_COIL) ew = (val != 0) ? 16'hFF00 : 16'h0000;
                else if (fc == FC_WR_REG) ew = val;
                else ew = {5'd0, q};
                rsp.push_back(ew[15:8]);
                rsp.push_back(ew[7:0]);
            end
        end
        c = 16'hFFFF;
        foreach (rsp[i]) c = crc16_byte(c, rsp[i]);
        rsp.push_back(c[7:0]);
        rsp.push_back(c[15:8]);
        if (mode == RSP_BROKEN) begin
            case ($urandom % 4)
                0: begin
                    k = $urandom_range(rsp.size() - 1, 0);
                    rsp[k][$urandom % 8] = ~rsp[k][$urandom % 8];
                end
                1: begin
                    k = $urandom_range(rsp.size() - 1, 0);
                    while (rsp.size() > k) void'(rsp.pop_back());
                end
                2: repeat ($urandom_range(3, 1)) rsp.push_back(8'($urandom));
                default: begin
                    k = $urandom_range(8, 1);
                    rsp.delete();
                    repeat (k) rsp.push_back(8'($urandom));
                end
            endcase
        end
        foreach (rsp[i]) push_simple(ACT_RX, 16'($urandom), rsp[i]);
        push_simple(ACT_END, 16'($urandom), 8'($urandom));
    endtask

    task automatic test_directed();
        push_beat(ACT_START, 8'hFF, 16'hFFFF, 16'hFFFF, 11'h7FF, 16'hFFFF, 8'hFF);
        push_simple(ACT_END, 16'd0, 8'd0);
        push_beat(ACT_START, FC_WR_REGS, 16'd0, 16'd0, 11'd0, 16'd0, 8'd0);
        push_simple(ACT_END, 16'd0, 8'd0);
        push_beat(ACT_START, FC_WR_REGS, 16'h1234, 16'd0, 11'd124, 16'd0, 8'd0);
        push_beat(ACT_START, FC_RD_HOLD, 16'h0001, 16'd0, 11'd2001, 16'd0, 8'd0);
        push_simple(ACT_PAYLOAD, 16'hFFFF, 8'd0);
        push_simple(ACT_END, 16'd0, 8'd0);
        push_simple(ACT_RX, 16'd0, 8'd1);
        push_simple(ACT_RX, 16'd0, 8'h03);
        push_simple(ACT_END, 16'd0, 8'd0);
        run_request(FC_WR_COIL, 11'd0, RSP_NORMAL);
        run_request(FC_WR_COILS, 11'd1, RSP_EXCEPT);
    endtask

    task automatic test_unit_extremes();
        set_unit(8'd0);
        run_request(FC_RD_COILS, 11'd9, RSP_NORMAL);
        run_request(FC_WR_REG, 11'd0, RSP_NORMAL);
        set_unit(8'hFF);
        run_request(FC_RD_INPUT, 11'd3, RSP_NORMAL);
        run_request(FC_WR_REGS, 11'd2, RSP_NORMAL);
        set_unit(8'($urandom));
        run_request(FC_RD_DISC, 11'd2000, RSP_NORMAL);
        run_request(FC_RD_HOLD, 11'd127, RSP_NORMAL);
        run_request(FC_WR_REGS, 11'd123, RSP_NORMAL);
    endtask

    task automatic test_random_traffic();
        logic [7:0]  codes[8] = '{FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT,
                                  FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS};
        logic [7:0]  fc;
        logic [10:0] q;
        int r, goal;
        goal = n_items + 320;
        while (n_items < goal) begin
            r = $urandom % 100;
            if (r < 8) begin
                push_beat(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                          11'($urandom), 16'($urandom), 8'($urandom));
                continue;
            end
            if (r < 12) set_unit(($urandom % 2) ? 8'd1 : 8'($urandom));
            fc = ($urandom % 12 == 0) ? 8'($urandom) : codes[$urandom % 8];
            q = ($urandom % 10 == 0) ? 11'($urandom) : 11'($urandom_range(20, 1));
            r = $urandom % 100;
            run_request(fc, q, r < 60 ? RSP_NORMAL : (r < 78 ? RSP_EXCEPT : RSP_BROKEN));
        end
    endtask

    // receiver backpressure
    int rx_cyc = 0;
    always @(posedge aclk) begin
        rx_cyc <= rx_cyc + 1;
        case (rx_cyc[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom);
            2'd2: m_tready <= (rx_cyc[2:0] == 3'd0);
            default: m_tready <= ($urandom % 4 != 0);
        endcase
    end

    always @(posedge aclk) begin
        beat_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[7:0], m_tlast, m_tdata[18:8], m_tdata[34:19], m_tdata[37:35]};
            if (got.kind == KIND_TX && got.last) n_frames++;
            if (got.kind == KIND_READ) n_reads++;
            if (got.kind == KIND_STATUS) n_status++;
            if (exp_q.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: actual %p", $realtime, got);
            end else begin
                want = exp_q.pop_front();
                if (got.kind !== want.kind || got.tx !== want.tx || got.last !== want.last
                    || got.idx !== want.idx || got.val !== want.val || got.st !== want.st) begin
                    errors++;
                    $display("%0t mismatch: expected %p actual %p", $realtime, want, got);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("[modbus_rtu_master_frame_engine_core] ERROR");
        $finish;
    end

    initial begin
        engine_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_unit_extremes();
        drain();
        test_random_traffic();
        drain();
        if (exp_q.size() != 0) errors++;
        $display("covered %0d input beats: %0d request frames, %0d read elements, %0d statuses",
                 n_items, n_frames, n_reads, n_status);
        if (errors == 0) begin
            $display("[modbus_rtu_master_frame_engine_core] OK");
        end else begin
            $display("[modbus_rtu_master_frame_engine_core] ERROR");
        end
        $finish;
    end
endmodule
